// File: hw/rtl/addressed_frame_deframer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the addressed frame deframer
// Clocked assertion helpers, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef ADDRESSED_FRAME_DEFRAMER_ASSERT_SVH
`define ADDRESSED_FRAME_DEFRAMER_ASSERT_SVH

`ifndef ASSERT_OFF
`define AFD_ASSERT(lbl, clk_s, rst_s, prop) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (prop)) \
		else $error("assertion failed");
`define AFD_ASSERT_NEVER(lbl, clk_s, rst_s, cond) \
	`AFD_ASSERT(lbl, clk_s, rst_s, !(cond))
`else
`define AFD_ASSERT(lbl, clk_s, rst_s, prop)
`define AFD_ASSERT_NEVER(lbl, clk_s, rst_s, cond)
`endif

`endif

// File: hw/rtl/afd_pkg.sv
// ----------------------------------------------------------------------------
// Addressed frame deframer package
// Frame constants, parser phase encoding and the result record.
// ----------------------------------------------------------------------------
package afd_pkg;

	localparam logic [7:0] START_BYTE = 8'h3A;
	localparam logic [7:0] TAIL_BYTE  = 8'h0D;

	typedef enum logic [2:0] {
		PH_HUNT  = 3'd0,
		PH_ADDR  = 3'd1,
		PH_CMD   = 3'd2,
		PH_LEN   = 3'd3,
		PH_DATA  = 3'd4,
		PH_SUMHI = 3'd5,
		PH_SUMLO = 3'd6,
		PH_END   = 3'd7
	} phase_t;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic [7:0] payload_index;
		logic [7:0] command_code;
		logic [7:0] frame_length;
		logic       frame_end;
		logic       frame_status;
	} res_t;

endpackage

// File: hw/rtl/afd_rx_if.sv
// ----------------------------------------------------------------------------
// Received byte channel
// Valid/ready channel carrying one serial byte per transfer.
// ----------------------------------------------------------------------------
interface afd_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// File: hw/rtl/afd_res_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying payload bytes and frame verdicts.
// ----------------------------------------------------------------------------
interface afd_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	logic [7:0] payload_index;
	logic [7:0] command_code;
	logic [7:0] frame_length;
	logic       frame_end;
	logic       frame_status;

	modport source (output valid, output payload_byte, output payload_index,
		output command_code, output frame_length, output frame_end,
		output frame_status, input ready);
	modport sink (input valid, input payload_byte, input payload_index,
		input command_code, input frame_length, input frame_end,
		input frame_status, output ready);
endinterface

// File: hw/rtl/addressed_frame_deframer.sv
// Each accepted byte passes through the input register, then the result register.
// Throughput: one byte per cycle unless the output stalls; the parser state update and
// 16-bit checksum add complete in the single stage between the two registers.
// Reset: arst_n clears the parser to hunting, all frame state and the station
// address to zero, and empties both registers; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Addressed frame deframer
// Parses addressed serial frames, emits payload bytes and a checksum verdict.
// ----------------------------------------------------------------------------
`include "addressed_frame_deframer_assert.svh"

module addressed_frame_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	afd_rx_if.sink      rx,
	afd_res_if.source   res
);

	logic [7:0]    station_q;
	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          advance;
	logic          p_valid;
	afd_pkg::res_t p_res;
	logic          res_valid_q;
	afd_pkg::res_t res_q;

	assign advance  = !res_valid_q || res.ready;
	assign rx.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			station_q <= 8'd0;
		end else if (cfg_we) begin
			station_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	afd_parser u_parser (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (valid_s1 && advance),
		.byte_in         (byte_s1),
		.station_address (station_q),
		.res_valid       (p_valid),
		.res             (p_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= p_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && p_valid) begin
			res_q <= p_res;
		end
	end

	assign res.valid         = res_valid_q;
	assign res.payload_byte  = res_q.payload_byte;
	assign res.payload_index = res_q.payload_index;
	assign res.command_code  = res_q.command_code;
	assign res.frame_length  = res_q.frame_length;
	assign res.frame_end     = res_q.frame_end;
	assign res.frame_status  = res_q.frame_status;

	`AFD_ASSERT(a_verdict_zero, clk, arst_n,
		res_valid_q && res_q.frame_end |-> res_q.payload_byte == 8'd0 && res_q.payload_index == 8'd0)
	`AFD_ASSERT_NEVER(a_data_no_status, clk, arst_n,
		res_valid_q && !res_q.frame_end && res_q.frame_status)
	`AFD_ASSERT(a_s1_hold, clk, arst_n, valid_s1 && !advance |=> valid_s1 && $stable(byte_s1))

endmodule

// File: hw/rtl/afd_parser.sv
// ----------------------------------------------------------------------------
// Frame parser
// Per-byte phase tracking, checksum accumulation and result generation.
// ----------------------------------------------------------------------------
module afd_parser (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  logic [7:0]     byte_in,
	input  logic [7:0]     station_address,
	output logic           res_valid,
	output afd_pkg::res_t  res
);

	afd_pkg::phase_t phase_q, phase_d;
	logic        match_q, match_d;
	logic [7:0]  cmd_q, cmd_d;
	logic [7:0]  len_q, len_d;
	logic [7:0]  seen_q, seen_d;
	logic [15:0] sum_q, sum_d;
	logic [15:0] rsum_q, rsum_d;
	logic [15:0] sum_add;
	logic [7:0]  seen_inc;

	assign sum_add  = sum_q + {8'd0, byte_in};
	assign seen_inc = seen_q + 8'd1;

	always_comb begin
		phase_d   = phase_q;
		match_d   = match_q;
		cmd_d     = cmd_q;
		len_d     = len_q;
		seen_d    = seen_q;
		sum_d     = sum_q;
		rsum_d    = rsum_q;
		res_valid = 1'b0;
		res.payload_byte  = 8'd0;
		res.payload_index = 8'd0;
		res.command_code  = cmd_q;
		res.frame_length  = len_q;
		res.frame_end     = 1'b0;
		res.frame_status  = 1'b0;
		case (phase_q)
			afd_pkg::PH_HUNT: begin
				if (byte_in == afd_pkg::START_BYTE) begin
					sum_d   = {8'd0, afd_pkg::START_BYTE} + {8'd0, afd_pkg::TAIL_BYTE};
					seen_d  = 8'd0;
					phase_d = afd_pkg::PH_ADDR;
				end
			end
			afd_pkg::PH_ADDR: begin
				match_d = (byte_in == station_address);
				sum_d   = sum_add;
				phase_d = afd_pkg::PH_CMD;
			end
			afd_pkg::PH_CMD: begin
				cmd_d   = byte_in;
				sum_d   = sum_add;
				phase_d = afd_pkg::PH_LEN;
			end
			afd_pkg::PH_LEN: begin
				len_d   = byte_in;
				sum_d   = sum_add;
				seen_d  = 8'd0;
				phase_d = (byte_in == 8'd0) ? afd_pkg::PH_SUMHI : afd_pkg::PH_DATA;
			end
			afd_pkg::PH_DATA: begin
				sum_d             = sum_add;
				res_valid         = match_q;
				res.payload_byte  = byte_in;
				res.payload_index = seen_q;
				seen_d            = seen_inc;
				if (seen_inc == len_q) begin
					phase_d = afd_pkg::PH_SUMHI;
				end
			end
			afd_pkg::PH_SUMHI: begin
				rsum_d  = {byte_in, 8'd0};
				phase_d = afd_pkg::PH_SUMLO;
			end
			afd_pkg::PH_SUMLO: begin
				rsum_d  = {rsum_q[15:8], byte_in};
				phase_d = afd_pkg::PH_END;
			end
			default: begin
				res_valid        = match_q;
				res.frame_end    = 1'b1;
				res.frame_status = (rsum_q != sum_q);
				phase_d          = afd_pkg::PH_HUNT;
			end
		endcase
		if (!step) begin
			res_valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= afd_pkg::PH_HUNT;
			match_q <= 1'b0;
			cmd_q   <= 8'd0;
			len_q   <= 8'd0;
			seen_q  <= 8'd0;
			sum_q   <= 16'd0;
			rsum_q  <= 16'd0;
		end else if (step) begin
			phase_q <= phase_d;
			match_q <= match_d;
			cmd_q   <= cmd_d;
			len_q   <= len_d;
			seen_q  <= seen_d;
			sum_q   <= sum_d;
			rsum_q  <= rsum_d;
		end
	end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Addressed frame deframer testbench
// Feeds directed and random serial byte streams, including broken frames and
// line noise, through the deframer. Random gaps are applied on both channels.
// A parser model tracks every accepted byte and queues the payload and verdict
// transfers it expects, and each output transfer is checked against them.
// ----------------------------------------------------------------------------
module tb;
	import afd_pkg::*;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_PAD    = 8;
	localparam int MAX_REPORTS  = 10;
	localparam int RANDOM_ITEMS = 1170;
	localparam int CFG_INTERVAL = 300;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [7:0] cfg_wdata;

	afd_rx_if  rx_ch ();
	afd_res_if res_ch ();

	addressed_frame_deframer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.rx        (rx_ch),
		.res       (res_ch)
	);

	// parser model state
	logic [7:0]  station;
	phase_t      prs_phase;
	logic        prs_hit;
	logic [7:0]  prs_cmd;
	logic [7:0]  prs_len;
	logic [7:0]  prs_count;
	logic [15:0] prs_sum;
	logic [15:0] prs_rx_sum;
	res_t        pending_results[$];

	logic [7:0]  payload_buf [0:255];

	bit rx_gaps_on;
	bit res_stalls_on;
	int ready_run;
	int ready_hold;

	int cycles;
	int bytes_sent;
	int frames_sent;
	int results_seen;
	int verdicts_seen;
	int checksum_fails_seen;
	int mismatches;

	always #10 clk = ~clk;

	function automatic res_t make_result(input logic [7:0] pbyte, input logic [7:0] pidx,
		input logic fend, input logic fstat);
		res_t r;
		r.payload_byte  = pbyte;
		r.payload_index = pidx;
		r.command_code  = prs_cmd;
		r.frame_length  = prs_len;
		r.frame_end     = fend;
		r.frame_status  = fstat;
		return r;
	endfunction

	function automatic void parse_byte(input logic [7:0] b);
		case (prs_phase)
			PH_HUNT: begin
				if (b == START_BYTE) begin
					prs_sum   = 16'(START_BYTE) + 16'(TAIL_BYTE);
					prs_count = 8'd0;
					prs_phase = PH_ADDR;
				end
			end
			PH_ADDR: begin
				prs_hit   = (b == station);
				prs_sum   = prs_sum + b;
				prs_phase = PH_CMD;
			end
			PH_CMD: begin
				prs_cmd   = b;
				prs_sum   = prs_sum + b;
				prs_phase = PH_LEN;
			end
			PH_LEN: begin
				prs_len   = b;
				prs_sum   = prs_sum + b;
				prs_count = 8'd0;
				if (b == 8'd0)
					prs_phase = PH_SUMHI;
				else
					prs_phase = PH_DATA;
			end
			PH_DATA: begin
				prs_sum = prs_sum + b;
				if (prs_hit)
					pending_results.push_back(make_result(b, prs_count, 1'b0, 1'b0));
				prs_count = prs_count + 8'd1;
				if (prs_count == prs_len)
					prs_phase = PH_SUMHI;
			end
			PH_SUMHI: begin
				prs_rx_sum = {b, 8'h00};
				prs_phase  = PH_SUMLO;
			end
			PH_SUMLO: begin
				prs_rx_sum[7:0] = b;
				prs_phase       = PH_END;
			end
			default: begin
				// end byte value is don't-care
				if (prs_hit)
					pending_results.push_back(make_result(8'd0, 8'd0, 1'b1,
						prs_rx_sum != prs_sum));
				prs_phase = PH_HUNT;
			end
		endcase
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// result sink back-pressure
	always @(negedge clk) begin
		if (!res_stalls_on) begin
			res_ch.ready <= 1'b1;
		end else if (ready_run > 0) begin
			res_ch.ready <= 1'b1;
			ready_run--;
		end else if (ready_hold > 0) begin
			res_ch.ready <= 1'b0;
			ready_hold--;
		end else begin
			res_ch.ready <= 1'b1;
			ready_run  = $urandom_range(0, 15);
			ready_hold = pick_gap();
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input res_t want, input res_t got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t %s: exp byte %02h idx %0d cmd %02h len %0d end %0b st %0b",
				$realtime, what,
				want.payload_byte, want.payload_index, want.command_code,
				want.frame_length, want.frame_end, want.frame_status,
				" | got byte %02h idx %0d cmd %02h len %0d end %0b st %0b",
				got.payload_byte, got.payload_index, got.command_code,
				got.frame_length, got.frame_end, got.frame_status);
	endtask

	always @(posedge clk) begin : result_check
		res_t got;
		res_t want;
		if (arst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			got.payload_byte  = res_ch.payload_byte;
			got.payload_index = res_ch.payload_index;
			got.command_code  = res_ch.command_code;
			got.frame_length  = res_ch.frame_length;
			got.frame_end     = res_ch.frame_end;
			got.frame_status  = res_ch.frame_status;
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected transfer", '0, got);
			end else begin
				want = pending_results.pop_front();
				if (got !== want)
					report_mismatch("mismatch", want, got);
				results_seen++;
				if (want.frame_end) begin
					verdicts_seen++;
					if (want.frame_status)
						checksum_fails_seen++;
				end
			end
		end
	end

	// enters and leaves just after a falling edge; valid stays up between bytes unless a gap is drawn
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = rx_gaps_on ? pick_gap() : 0;
		if (gap > 0) begin
			rx_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_byte <= b;
		do @(posedge clk); while (rx_ch.ready !== 1'b1);
		parse_byte(b);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		rx_ch.valid <= 1'b0;
		do @(negedge clk); while (pending_results.size() != 0);
		repeat (DRAIN_PAD) @(negedge clk);
	endtask

	task automatic set_station(input logic [7:0] addr);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= addr;
		@(negedge clk);
		cfg_we  <= 1'b0;
		station = addr;
	endtask

	// payload taken from payload_buf; sum_flip corrupts the transmitted checksum
	task automatic send_frame(input logic [7:0] addr, input logic [7:0] cmd,
		input logic [7:0] len, input logic [15:0] sum_flip, input logic [7:0] tail);
		logic [15:0] sum;
		sum = 16'(START_BYTE) + 16'(TAIL_BYTE) + addr + cmd + len;
		for (int i = 0; i < len; i++)
			sum = sum + payload_buf[i];
		sum = sum ^ sum_flip;
		send_byte(START_BYTE);
		send_byte(addr);
		send_byte(cmd);
		send_byte(len);
		for (int i = 0; i < len; i++)
			send_byte(payload_buf[i]);
		send_byte(sum[15:8]);
		send_byte(sum[7:0]);
		send_byte(tail);
		frames_sent++;
	endtask

	task automatic send_noise(input int count);
		logic [7:0] b;
		for (int i = 0; i < count; i++) begin
			b = 8'($urandom);
			if (b == START_BYTE)
				b = ~b;
			send_byte(b);
		end
	endtask

	task automatic send_random_frame();
		logic [7:0]  addr;
		logic [7:0]  len;
		logic [15:0] flip;
		int          r;
		addr = ($urandom_range(0, 9) < 7) ? station : 8'($urandom);
		r = $urandom_range(0, 99);
		if (r < 20)
			len = 8'd0;
		else if (r < 80)
			len = 8'($urandom_range(1, 8));
		else if (r < 97)
			len = 8'($urandom_range(9, 40));
		else
			len = 8'($urandom_range(200, 255));
		for (int i = 0; i < len; i++)
			payload_buf[i] = 8'($urandom);
		flip = 16'd0;
		if ($urandom_range(0, 99) < 15)
			flip = 16'($urandom_range(1, 65535));
		send_frame(addr, 8'($urandom), len, flip, 8'($urandom));
	endtask

	// truncated frame, optionally with a stray start byte, then fill to resync
	task automatic send_broken_frame();
		logic [7:0] len;
		int         cut;
		len = 8'($urandom_range(1, 20));
		cut = $urandom_range(0, len + 2);
		send_byte(START_BYTE);
		send_byte(($urandom_range(0, 3) != 0) ? station : 8'($urandom));
		send_byte(8'($urandom));
		send_byte(len);
		for (int i = 0; i < cut; i++)
			send_byte(($urandom_range(0, 4) == 0) ? START_BYTE : 8'($urandom));
		if ($urandom_range(0, 1) == 0)
			drain();
		while (prs_phase != PH_HUNT)
			send_byte(8'($urandom));
	endtask

	task automatic test_reset_address();
		payload_buf[0] = 8'h00;
		payload_buf[1] = 8'hFF;
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(TAIL_BYTE);
		send_frame(8'h00, 8'h00, 8'd2, 16'h0000, TAIL_BYTE);
	endtask

	task automatic test_station_extremes();
		set_station(8'hFF);
		payload_buf[0] = START_BYTE;
		send_frame(8'hFF, 8'hFF, 8'd1, 16'h0000, START_BYTE);
		// foreign frame full of start bytes must stay silent
		payload_buf[0] = START_BYTE;
		payload_buf[1] = START_BYTE;
		payload_buf[2] = START_BYTE;
		send_frame(8'h00, 8'h12, 8'd3, 16'h0000, 8'h00);
		send_frame(8'hFF, 8'h00, 8'd0, 16'h0000, 8'hFF);
	endtask

	task automatic test_checksum_errors();
		set_station(8'h00);
		send_frame(8'h00, 8'h7E, 8'd0, 16'h0100, TAIL_BYTE);
		payload_buf[0] = 8'h81;
		payload_buf[1] = 8'h5A;
		send_frame(8'h00, 8'h81, 8'd2, 16'h0001, TAIL_BYTE);
	endtask

	task automatic test_longest_frame();
		set_station(START_BYTE);
		for (int i = 0; i < 255; i++)
			payload_buf[i] = 8'hFF;
		send_frame(START_BYTE, 8'hA5, 8'd255, 16'h0000, TAIL_BYTE);
		for (int i = 0; i < 255; i++)
			payload_buf[i] = 8'($urandom);
		send_frame(START_BYTE, 8'h5A, 8'd255, 16'h0080, TAIL_BYTE);
	endtask

	task automatic test_random_traffic();
		int target;
		int next_cfg;
		int r;
		target   = bytes_sent + RANDOM_ITEMS;
		next_cfg = bytes_sent + CFG_INTERVAL;
		while (bytes_sent < target) begin
			if (bytes_sent >= next_cfg) begin
				r = $urandom_range(0, 3);
				if (r == 0)
					set_station(8'h00);
				else if (r == 1)
					set_station(8'hFF);
				else
					set_station(8'($urandom));
				rx_gaps_on    = $urandom_range(0, 3) != 0;
				res_stalls_on = $urandom_range(0, 3) != 0;
				next_cfg      = bytes_sent + CFG_INTERVAL;
			end
			r = $urandom_range(0, 99);
			if (r < 75) begin
				send_random_frame();
			end else if (r < 85) begin
				send_noise($urandom_range(1, 6));
			end else if (r < 95) begin
				send_broken_frame();
			end else begin
				send_random_frame();
				drain();
			end
		end
	endtask

	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = 8'h00;
		rx_ch.valid   = 1'b0;
		rx_ch.rx_byte = 8'h00;
		res_ch.ready  = 1'b0;
		station       = 8'h00;
		prs_phase     = PH_HUNT;
		prs_hit       = 1'b0;
		prs_cmd       = 8'h00;
		prs_len       = 8'h00;
		prs_count     = 8'h00;
		prs_sum       = 16'h0000;
		prs_rx_sum    = 16'h0000;
		rx_gaps_on    = 1'b1;
		res_stalls_on = 1'b1;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_address();
		test_station_extremes();
		test_checksum_errors();
		test_longest_frame();
		test_random_traffic();
		drain();

		$display("Sent %0d frames in %0d bytes across several station addresses",
			frames_sent, bytes_sent);
		$display("Checked %0d transfers: %0d verdicts, %0d flagged bad checksum",
			results_seen, verdicts_seen, checksum_fails_seen);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/afd_pkg.sv
hw/rtl/afd_rx_if.sv
hw/rtl/afd_res_if.sv
hw/rtl/afd_parser.sv
hw/rtl/addressed_frame_deframer.sv
tb/tb.sv
